FILE: hw/rtl/ffha_pkg.sv
// shared types and constants for the first-fit heap allocator
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;
  localparam int HEAP_BYTES   = 16777216;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_BLOCKS   = 64;
  localparam int AW = 24;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = IW + 1;
  localparam int RW = 25;

  localparam logic [AW-1:0] HEAP_DATA = AW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_OOM   = 2'd2;
  localparam logic [1:0] ST_NOBLK = 2'd3;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] size;
    logic          free;
  } entry_t;

  // per-cell update operation broadcast by the controller
  typedef enum logic [2:0] {
    OP_HOLD, OP_INIT, OP_SPLIT, OP_MARK, OP_MERGE
  } cell_op_t;

  typedef struct packed {
    cell_op_t      op;
    logic [IW-1:0] idx;
    logic [AW-1:0] need;
    logic [AW-1:0] grow;
  } cell_cmd_t;
endpackage
`default_nettype wire

FILE: hw/rtl/first_fit_heap_allocator_unit.sv
// top level: command sequencer driving a chain of block-table cells
// alloc and free pass search and act states before the result; reinit, zero size and
// others go straight to the result; one command in flight at a time
// the first-fit and address searches use a registered hit vector with a
// priority pick over all cells; freeing a used block adds next and previous merge checks
// synchronous active-low reset restores the single free heap block
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [24:0] in_request_bytes,
  input  wire logic [23:0] in_block_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [23:0]      out_data_address,
  output logic [23:0]      out_granted_bytes,
  output logic [23:0]      out_used_bytes,
  output logic             out_first_oom
);
  import ffha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRCH  = 6'b000010,
    S_ACT   = 6'b000100,
    S_MRGN  = 6'b001000,
    S_MRGP  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  entry_t ent [MAX_BLOCKS];
  cell_cmd_t ccmd;
  logic [1:0]  cmd_r;
  logic [RW-1:0] need_r;
  logic [AW-1:0] addr_r;
  logic [MAX_BLOCKS-1:0] hit_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] used_r, used_nxt;
  logic oom_r, oom_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [AW-1:0] da_r, da_nxt, gb_r, gb_nxt;
  logic fo_r, fo_nxt;
  logic found;
  logic [IW-1:0] pick;
  logic [RW:0]   need_sum;
  logic [RW-1:0] need_c;

  // cell chain
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffha_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(IW'(g)), .cmd(ccmd),
      .prev_e(ent[(g == 0) ? 0 : g - 1]),
      .next_e(ent[(g == MAX_BLOCKS - 1) ? g : g + 1]),
      .e_q(ent[g])
    );
  end

  // round up to alignment; saturate on carry so huge requests find nothing
  assign need_sum = {1'b0, in_request_bytes} + (RW+1)'(ALIGN_BYTES - 1);
  assign need_c   = need_sum[RW] ? ~RW'(ALIGN_BYTES - 1)
                                 : (need_sum[RW-1:0] & ~RW'(ALIGN_BYTES - 1));

  // first hit in the registered match vector
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
      if (hit_r[k]) begin
        found = 1'b1;
        pick  = IW'(k);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    used_nxt  = used_r;
    oom_nxt   = oom_r;
    idx_nxt   = idx_r;
    st_nxt = st_r; da_nxt = da_r; gb_nxt = gb_r; fo_nxt = fo_r;
    ccmd = '{op: OP_HOLD, idx: idx_r, need: need_r[AW-1:0], grow: '0};
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        st_nxt = ST_OK; da_nxt = '0; gb_nxt = '0; fo_nxt = 1'b0;
        state_nxt = S_SRCH;
        if (in_command == CMD_INIT) begin
          ccmd.op = OP_INIT;
          count_nxt = CW'(1); used_nxt = '0; oom_nxt = 1'b0;
          state_nxt = S_OUT;
        end else if (in_command == CMD_ALLOC && in_request_bytes == '0) begin
          st_nxt = ST_ZERO;
          state_nxt = S_OUT;
        end else if (in_command != CMD_ALLOC && in_command != CMD_FREE) begin
          state_nxt = S_OUT;
        end
      end
      S_SRCH: state_nxt = S_ACT;
      S_ACT: begin
        idx_nxt = pick;
        state_nxt = S_OUT;
        if (cmd_r == CMD_ALLOC) begin
          if (!found) begin
            st_nxt = ST_OOM;
            fo_nxt = ~oom_r;
            oom_nxt = 1'b1;
          end else begin
            da_nxt = ent[pick].start + HDR;
            if ({1'b0, ent[pick].size} >= need_r + RW'(HEADER_BYTES + ALIGN_BYTES)
                && count_r < CW'(MAX_BLOCKS)) begin
              ccmd = '{op: OP_SPLIT, idx: pick, need: need_r[AW-1:0], grow: '0};
              count_nxt = count_r + CW'(1);
              gb_nxt = need_r[AW-1:0];
              used_nxt = used_r + need_r[AW-1:0];
            end else begin
              ccmd = '{op: OP_MARK, idx: pick, need: '0, grow: '0};
              gb_nxt = ent[pick].size;
              used_nxt = used_r + ent[pick].size;
            end
          end
        end else begin
          if (!found) st_nxt = ST_NOBLK;
          else if (!ent[pick].free) begin
            ccmd = '{op: OP_MARK, idx: pick, need: '0, grow: '0};
            used_nxt = used_r - ent[pick].size;
            state_nxt = S_MRGN;
          end
        end
      end
      S_MRGN: begin
        state_nxt = S_MRGP;
        if (CW'(idx_r) + CW'(1) < count_r && ent[idx_r + IW'(1)].free) begin
          ccmd = '{op: OP_MERGE, idx: idx_r, need: '0,
                   grow: HDR + ent[idx_r + IW'(1)].size};
          count_nxt = count_r - CW'(1);
        end
      end
      S_MRGP: begin
        state_nxt = S_OUT;
        if (idx_r != '0 && ent[idx_r - IW'(1)].free) begin
          ccmd = '{op: OP_MERGE, idx: idx_r - IW'(1), need: '0,
                   grow: HDR + ent[idx_r].size};
          count_nxt = count_r - CW'(1);
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // search match vector, captured command and result registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r  <= in_command;
      need_r <= need_c;
      addr_r <= in_block_address;
    end
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (cmd_r == CMD_ALLOC)
        hit_r[k] <= (CW'(k) < count_r) && ent[k].free
                    && ({1'b0, ent[k].size} >= need_r);
      else
        hit_r[k] <= (CW'(k) < count_r) && ({1'b0, ent[k].start} + RW'(HEADER_BYTES)
                    == {1'b0, addr_r});
    end
    idx_r <= idx_nxt;
    st_r <= st_nxt; da_r <= da_nxt; gb_r <= gb_nxt; fo_r <= fo_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CW'(1);
      used_r  <= '0;
      oom_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      used_r  <= used_nxt;
      oom_r   <= oom_nxt;
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_OUT);
  assign out_status        = st_r;
  assign out_data_address  = da_r;
  assign out_granted_bytes = gb_r;
  assign out_used_bytes    = used_r;
  assign out_first_oom     = fo_r;

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CW'(MAX_BLOCKS)) else $error("entry count out of range");
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_oom_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_oom |-> out_status == ST_OOM) else $error("first_oom without oom");
endmodule
`default_nettype wire

FILE: hw/rtl/ffha_cell.sv
// one table cell: holds one heap block entry and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module ffha_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [ffha_pkg::IW-1:0] my_idx,
  input  wire ffha_pkg::cell_cmd_t    cmd,
  input  wire ffha_pkg::entry_t       prev_e,
  input  wire ffha_pkg::entry_t       next_e,
  output ffha_pkg::entry_t            e_q
);
  import ffha_pkg::*;
  entry_t e_r, e_nxt;

  // shift right on split, left on merge, local update at the target; init reloads the reset entry
  always_comb begin
    e_nxt = e_r;
    unique case (cmd.op)
      OP_INIT: begin
        e_nxt.start = '0;
        e_nxt.size  = HEAP_DATA;
        e_nxt.free  = (my_idx == '0);
      end
      OP_SPLIT: begin
        if (my_idx == cmd.idx) begin
          e_nxt.size = cmd.need;
          e_nxt.free = 1'b0;
        end else if (my_idx == cmd.idx + IW'(1)) begin
          // remainder of the block split by the left neighbor
          e_nxt.start = prev_e.start + HDR + cmd.need;
          e_nxt.size  = prev_e.size - cmd.need - HDR;
          e_nxt.free  = 1'b1;
        end else if (my_idx > cmd.idx) begin
          e_nxt = prev_e;
        end
      end
      OP_MARK: begin
        if (my_idx == cmd.idx) e_nxt.free = ~e_r.free;
      end
      OP_MERGE: begin
        if (my_idx == cmd.idx) e_nxt.size = e_r.size + cmd.grow;
        else if (my_idx > cmd.idx) e_nxt = next_e;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.start <= '0;
      e_r.size  <= HEAP_DATA;
      e_r.free  <= (my_idx == '0);
    end else begin
      e_r <= e_nxt;
    end
  end

  assign e_q = e_r;
endmodule
`default_nettype wire

FILE: verif/first_fit_heap_allocator_unit_checker.sv
// checker: watches both channels, predicts allocator results and compares them
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_unit_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [24:0] in_request_bytes,
  input  wire logic [23:0] in_block_address,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_status,
  input  wire logic [23:0] out_data_address,
  input  wire logic [23:0] out_granted_bytes,
  input  wire logic [23:0] out_used_bytes,
  input  wire logic        out_first_oom,
  output int               error_count,
  output int               pending_count
);
  import ffha_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] data_address;
    logic [23:0] granted_bytes;
    logic [23:0] used_bytes;
    logic        first_oom;
  } alloc_result_t;

  // shadow copy of the block table
  logic [31:0]   blk_start [MAX_BLOCKS];
  logic [31:0]   blk_size [MAX_BLOCKS];
  logic          blk_free [MAX_BLOCKS];
  int            blk_count;
  logic [31:0]   heap_used;
  logic          oom_seen;
  alloc_result_t result_queue[$];

  assign pending_count = result_queue.size();

  function automatic void heap_restore();
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      blk_start[k] = 0;
      blk_size[k] = 0;
      blk_free[k] = 1'b0;
    end
    blk_size[0] = HEAP_BYTES - HEADER_BYTES;
    blk_free[0] = 1'b1;
    blk_count = 1;
    heap_used = 0;
    oom_seen = 1'b0;
  endfunction

  // fold entry j+1 into entry j
  function automatic void absorb_next(int j);
    blk_size[j] += HEADER_BYTES + blk_size[j+1];
    for (int k = j + 1; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_size[k] = blk_size[k+1];
      blk_free[k] = blk_free[k+1];
    end
    blk_count--;
  endfunction

  function automatic alloc_result_t heap_apply(logic [1:0] cmd, logic [24:0] req,
                                               logic [23:0] addr);
    alloc_result_t r;
    logic [31:0] need;
    int hit;
    r = '0;
    hit = -1;
    if (cmd == CMD_ALLOC) begin
      if (req == 0) begin
        r.status = ST_ZERO;
      end else begin
        need = ((32'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        for (int k = 0; k < blk_count && hit < 0; k++)
          if (blk_free[k] && blk_size[k] >= need) hit = k;
        if (hit < 0) begin
          r.status = ST_OOM;
          r.first_oom = !oom_seen;
          oom_seen = 1'b1;
        end else begin
          if (blk_size[hit] >= need + HEADER_BYTES + ALIGN_BYTES && blk_count < MAX_BLOCKS)
          begin
            for (int k = blk_count; k > hit + 1; k--) begin
              blk_start[k] = blk_start[k-1];
              blk_size[k] = blk_size[k-1];
              blk_free[k] = blk_free[k-1];
            end
            blk_start[hit+1] = blk_start[hit] + HEADER_BYTES + need;
            blk_size[hit+1] = blk_size[hit] - need - HEADER_BYTES;
            blk_free[hit+1] = 1'b1;
            blk_size[hit] = need;
            blk_count++;
          end
          blk_free[hit] = 1'b0;
          heap_used += blk_size[hit];
          r.data_address = 24'(blk_start[hit] + HEADER_BYTES);
          r.granted_bytes = 24'(blk_size[hit]);
        end
      end
    end else if (cmd == CMD_FREE) begin
      for (int k = 0; k < blk_count && hit < 0; k++)
        if (blk_start[k] + HEADER_BYTES == 32'(addr)) hit = k;
      if (hit < 0) begin
        r.status = ST_NOBLK;
      end else if (!blk_free[hit]) begin
        blk_free[hit] = 1'b1;
        heap_used -= blk_size[hit];
        if (hit + 1 < blk_count && blk_free[hit+1]) absorb_next(hit);
        if (hit > 0 && blk_free[hit-1]) absorb_next(hit - 1);
      end
    end else if (cmd == CMD_INIT) begin
      heap_restore();
    end
    r.used_bytes = heap_used[23:0];
    return r;
  endfunction

  // predict on each input beat, compare on each result beat
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      heap_restore();
      result_queue.delete();
      error_count <= 0;
    end else begin
      if (in_valid && in_ready)
        result_queue.push_back(heap_apply(in_command, in_request_bytes, in_block_address));
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d", $time, out_status);
          error_count <= error_count + 1;
        end else begin
          want = result_queue.pop_front();
          if (want.status !== out_status || want.data_address !== out_data_address ||
              want.granted_bytes !== out_granted_bytes ||
              want.used_bytes !== out_used_bytes || want.first_oom !== out_first_oom) begin
            $display("%0t: mismatch expected st=%0d addr=%h gr=%h used=%h oom=%b", $time,
                     want.status, want.data_address, want.granted_bytes, want.used_bytes,
                     want.first_oom);
            $display("%0t:          actual   st=%0d addr=%h gr=%h used=%h oom=%b", $time,
                     out_status, out_data_address, out_granted_bytes, out_used_bytes,
                     out_first_oom);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: verif/first_fit_heap_allocator_unit_tb.sv
// testbench top: drives allocator commands and reports the verdict
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_unit_tb;
  import ffha_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_INIT;
  logic [24:0] in_request_bytes = '0;
  logic [23:0] in_block_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [23:0] out_data_address;
  logic [23:0] out_granted_bytes;
  logic [23:0] out_used_bytes;
  logic        out_first_oom;
  int          error_count;
  int          pending_count;
  int          cycle_count = 0;
  logic [23:0] live_addrs[$];

  first_fit_heap_allocator_unit dut (.*);

  first_fit_heap_allocator_unit_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("first_fit_heap_allocator_unit_tb: errors");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
        @(posedge clk);
        out_ready <= 1'b0;
      end
      @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  // remember granted addresses so frees hit real blocks
  always @(posedge clk)
    if (rst_n && out_valid && out_ready && out_status == ST_OK && out_granted_bytes != 0)
      live_addrs.push_back(out_data_address);

  // valid drops only during an idle gap, so back-to-back beats keep it high
  task automatic send_beat(logic [1:0] cmd, logic [24:0] req, logic [23:0] addr);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_request_bytes <= req;
    in_block_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [24:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 25'($urandom);
      1:       return 25'($urandom_range(0, 1 << 20));
      default: return 25'($urandom_range(1, 600));
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int idx;
    logic [23:0] a;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: zero size, extremes, exact fits, bad frees, double free, oom
    send_beat(CMD_ALLOC, 25'd0, 24'd0);
    send_beat(CMD_ALLOC, 25'd1, 24'd0);
    send_beat(CMD_ALLOC, 25'd16, 24'd0);
    send_beat(CMD_ALLOC, 25'd17, 24'd0);
    send_beat(CMD_FREE, 25'd0, 24'd0);
    send_beat(CMD_FREE, 25'd0, 24'd25);
    send_beat(CMD_FREE, 25'd0, 24'hFFFFFF);
    send_beat(CMD_FREE, 25'd0, 24'd24);
    send_beat(CMD_FREE, 25'd0, 24'd24);
    send_beat(CMD_ALLOC, 25'h1FFFFFF, 24'd0);
    send_beat(CMD_ALLOC, 25'h1000000, 24'd0);
    send_beat(CMD_ALLOC, 25'h1000000, 24'd0);
    send_beat(2'd3, 25'h1FFFFFF, 24'hFFFFFF);
    send_beat(CMD_INIT, 25'd0, 24'd0);
    send_beat(CMD_ALLOC, 25'(HEAP_BYTES - HEADER_BYTES), 24'd0);
    send_beat(CMD_ALLOC, 25'd5, 24'd0);
    send_beat(CMD_FREE, 25'd0, 24'd24);
    send_beat(CMD_ALLOC, 25'(HEAP_BYTES - 2 * HEADER_BYTES - 16), 24'd0);
    send_beat(CMD_ALLOC, 25'd16, 24'd0);
    send_beat(CMD_ALLOC, 25'd1, 24'd0);
    send_beat(CMD_INIT, 25'd0, 24'd0);
    drain();
    live_addrs.delete();
    // random: mostly allocs and frees of live blocks, filling the table often
    for (int n = 0; n < 1880; n++) begin
      if (n == 900) begin
        drain();
        repeat (6) @(posedge clk);
      end
      idx = $urandom_range(0, 99);
      if (idx < 50) begin
        send_beat(CMD_ALLOC, pick_size(), 24'($urandom));
      end else if (idx < 90 && live_addrs.size() != 0) begin
        idx = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[idx];
        live_addrs.delete(idx);
        send_beat(CMD_FREE, 25'($urandom), a);
      end else if (idx < 97) begin
        a = ($urandom_range(0, 1)) ? 24'($urandom) : 24'($urandom_range(0, 4096));
        send_beat(CMD_FREE, 25'($urandom), a);
      end else if (idx < 99) begin
        send_beat(2'd3, 25'($urandom), 24'($urandom));
      end else begin
        drain();
        live_addrs.delete();
        send_beat(CMD_INIT, 25'($urandom), 24'($urandom));
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("first_fit_heap_allocator_unit_tb: clean");
    end else begin
      $display("first_fit_heap_allocator_unit_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_cell.sv
hw/rtl/first_fit_heap_allocator_unit.sv
verif/first_fit_heap_allocator_unit_checker.sv
verif/first_fit_heap_allocator_unit_tb.sv
